>>> hdl/ckeb_pkg.sv
// ---------------------------------------------------------------------------
// ckeb_pkg
// shared types, constants and helper functions of the chroma key compositor
// ---------------------------------------------------------------------------
package ckeb_pkg;

    // default frame limits
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // configuration register file
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam int MIN_SIZE    = 3;

    // stream layout
    localparam int ITEM_W      = 89;
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 48;
    localparam int COORD_W     = 11;
    localparam int WORD_W      = 25;
    localparam int GREEN_BIT   = 24;
    localparam int SUM_W       = 12;

    // key test constants
    localparam logic [8:0]  HUE_PIVOT   = 9'd105;
    localparam logic [9:0]  MARGIN_IN   = 10'd105;
    localparam logic [9:0]  MARGIN_OUT  = 10'd255;
    localparam logic [8:0]  W1_HUE_LO   = 9'd65;
    localparam logic [8:0]  W1_HUE_HI   = 9'd145;
    localparam logic [15:0] W1_SAT_LO   = 16'd16384;
    localparam logic [15:0] W1_LIT_LO   = 16'd9830;
    localparam logic [15:0] W1_LIT_HI   = 16'd46859;
    localparam logic [8:0]  W2_HUE_LO   = 9'd90;
    localparam logic [8:0]  W2_HUE_HI   = 9'd120;
    localparam logic [15:0] W2_SAT_LO   = 16'd32768;
    localparam logic [15:0] W2_LIT_LO   = 16'd46858;
    localparam logic [15:0] W2_LIT_HI   = 16'd55706;

    // floor(x/9) for x below 2296 as (x * 3641) >> 15
    localparam logic [11:0] DIV9_MUL    = 12'd3641;

    // one input pixel, hue in the lowest bits
    typedef struct packed {
        logic [7:0]  back_blue;
        logic [7:0]  back_green;
        logic [7:0]  back_red;
        logic [7:0]  fore_blue;
        logic [7:0]  fore_green;
        logic [7:0]  fore_red;
        logic [15:0] lightness;
        logic [15:0] saturation;
        logic [8:0]  hue;
    } pix_t;

    // position of a pixel and which results it causes
    typedef struct packed {
        logic [COORD_W-1:0] int_col;
        logic [COORD_W-1:0] int_row;
        logic [COORD_W-1:0] bdr_col;
        logic [COORD_W-1:0] bdr_row;
        logic               interior;
        logic               border;
    } pos_t;

    // window statistics handed to the output stage
    typedef struct packed {
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic [23:0]      center_rgb;
        logic             mixed;
        logic [23:0]      cur_rgb;
    } blend_t;

    function automatic logic key_is_green(
        input logic [8:0]  hue,
        input logic [15:0] sat,
        input logic [15:0] lit
    );
        logic [8:0] dist_a;
        logic [8:0] dist_d;
        logic       win1;
        logic       win2;
        logic [9:0] margin;
        logic [9:0] rhs;
        dist_a = (hue > HUE_PIVOT) ? hue - HUE_PIVOT : HUE_PIVOT - hue;
        dist_d = (hue > dist_a) ? hue - dist_a : dist_a - hue;
        win1 = (hue > W1_HUE_LO) && (hue < W1_HUE_HI) && (sat > W1_SAT_LO) &&
               (lit > W1_LIT_LO) && (lit < W1_LIT_HI);
        win2 = (hue > W2_HUE_LO) && (hue < W2_HUE_HI) && (sat > W2_SAT_LO) &&
               (lit > W2_LIT_LO) && (lit < W2_LIT_HI);
        margin = (win1 || win2) ? MARGIN_IN : MARGIN_OUT;
        rhs = margin + 10'(dist_a);
        return {dist_d, 1'b0} > rhs;
    endfunction

    function automatic logic [7:0] div9(input logic [SUM_W-1:0] x);
        logic [23:0] prod;
        prod = 24'(x) * 24'(DIV9_MUL);
        return prod[22:15];
    endfunction

endpackage

>>> hdl/ckeb_ram.sv
// ---------------------------------------------------------------------------
// ckeb_ram
// simple dual port ram, one write port, one read port with registered data
// ---------------------------------------------------------------------------
module ckeb_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/ckeb_pos.sv
// ---------------------------------------------------------------------------
// ckeb_pos
// frame size registers and raster position counters
// ---------------------------------------------------------------------------
module ckeb_pos #(
    parameter int MAX_WIDTH  = ckeb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ckeb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ckeb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ckeb_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             advance,
    output logic [$clog2(MAX_WIDTH)-1:0]     col,
    output ckeb_pkg::pos_t                   pos
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WSW = ($clog2(MAX_WIDTH + 1) > ckeb_pkg::CFG_W) ?
                         $clog2(MAX_WIDTH + 1) : ckeb_pkg::CFG_W;
    localparam int HSW = ($clog2(MAX_HEIGHT + 1) > ckeb_pkg::CFG_W) ?
                         $clog2(MAX_HEIGHT + 1) : ckeb_pkg::CFG_W;
    localparam int XCW = CW + ckeb_pkg::COORD_W;
    localparam int XRW = RW + ckeb_pkg::COORD_W;

    logic [ckeb_pkg::CFG_W-1:0] frame_width_reg,  frame_width_next;
    logic [ckeb_pkg::CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [CW-1:0]              col_reg, col_next;
    logic [RW-1:0]              row_reg, row_next;

    logic [WSW-1:0] fw_ext, w_eff;
    logic [HSW-1:0] fh_ext, h_eff;
    logic [CW-1:0]  col_last;
    logic [RW-1:0]  row_last;
    logic [XCW-1:0] col_ext;
    logic [XRW-1:0] row_ext;

    // clamp the frame size to [3, max]
    always_comb begin
        fw_ext = WSW'(frame_width_reg);
        fh_ext = HSW'(frame_height_reg);
        priority if (fw_ext < WSW'(ckeb_pkg::MIN_SIZE)) begin
            w_eff = WSW'(ckeb_pkg::MIN_SIZE);
        end else if (fw_ext > WSW'(MAX_WIDTH)) begin
            w_eff = WSW'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        priority if (fh_ext < HSW'(ckeb_pkg::MIN_SIZE)) begin
            h_eff = HSW'(ckeb_pkg::MIN_SIZE);
        end else if (fh_ext > HSW'(MAX_HEIGHT)) begin
            h_eff = HSW'(MAX_HEIGHT);
        end else begin
            h_eff = fh_ext;
        end
        col_last = CW'(w_eff - WSW'(1));
        row_last = RW'(h_eff - HSW'(1));
    end

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                ckeb_pkg::REG_FRAME_WIDTH:  frame_width_next  = cfg_wdata;
                ckeb_pkg::REG_FRAME_HEIGHT: frame_height_next = cfg_wdata;
                default:                    frame_width_next  = frame_width_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end else if (advance) begin
            if (col_reg == col_last) begin
                col_next = '0;
                row_next = (row_reg == row_last) ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= ckeb_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= ckeb_pkg::FRAME_HEIGHT_RST;
            col_reg          <= '0;
            row_reg          <= '0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
        end
    end

    always_comb begin
        col_ext      = XCW'(col_reg);
        row_ext      = XRW'(row_reg);
        pos.int_col  = ckeb_pkg::COORD_W'(col_ext - XCW'(1));
        pos.int_row  = ckeb_pkg::COORD_W'(row_ext - XRW'(1));
        pos.bdr_col  = ckeb_pkg::COORD_W'(col_ext);
        pos.bdr_row  = ckeb_pkg::COORD_W'(row_ext);
        pos.interior = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
        pos.border   = (row_reg == '0) || (row_reg == row_last) ||
                       (col_reg == '0) || (col_reg == col_last);
    end

    assign col = col_reg;

endmodule

>>> hdl/ckeb_window.sv
// ---------------------------------------------------------------------------
// ckeb_window
// key test, hard selection and the 3x3 window statistics
// ---------------------------------------------------------------------------
module ckeb_window (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             shift_en,
    input  ckeb_pkg::pix_t                   pix,
    input  logic [ckeb_pkg::WORD_W-1:0]      up_word,
    input  logic [ckeb_pkg::WORD_W-1:0]      mid_word,
    output logic [ckeb_pkg::WORD_W-1:0]      cur_word,
    output ckeb_pkg::blend_t                 blend
);

    // two previous window columns: up, mid, cur of each
    logic [ckeb_pkg::WORD_W-1:0] cols_reg [6];
    logic [ckeb_pkg::WORD_W-1:0] win [9];
    logic                        green;
    logic [8:0]                  green_bits;
    logic [ckeb_pkg::SUM_W-1:0]  acc_r, acc_g, acc_b;

    always_comb begin
        green = ckeb_pkg::key_is_green(pix.hue, pix.saturation, pix.lightness);
        if (green) begin
            cur_word = {1'b1, pix.back_blue, pix.back_green, pix.back_red};
        end else begin
            cur_word = {1'b0, pix.fore_blue, pix.fore_green, pix.fore_red};
        end
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            win[i] = cols_reg[i];
        end
        win[6] = up_word;
        win[7] = mid_word;
        win[8] = cur_word;
        acc_r = '0;
        acc_g = '0;
        acc_b = '0;
        for (int i = 0; i < 9; i++) begin
            green_bits[i] = win[i][ckeb_pkg::GREEN_BIT];
            acc_r = acc_r + ckeb_pkg::SUM_W'(win[i][7:0]);
            acc_g = acc_g + ckeb_pkg::SUM_W'(win[i][15:8]);
            acc_b = acc_b + ckeb_pkg::SUM_W'(win[i][23:16]);
        end
        blend.sum_r      = acc_r;
        blend.sum_g      = acc_g;
        blend.sum_b      = acc_b;
        blend.center_rgb = win[4][23:0];
        blend.mixed      = !((&green_bits) || !(|green_bits));
        blend.cur_rgb    = cur_word[23:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                cols_reg[i] <= '0;
            end
        end else if (shift_en) begin
            cols_reg[0] <= cols_reg[3];
            cols_reg[1] <= cols_reg[4];
            cols_reg[2] <= cols_reg[5];
            cols_reg[3] <= up_word;
            cols_reg[4] <= mid_word;
            cols_reg[5] <= cur_word;
        end
    end

endmodule

>>> hdl/ckeb_out.sv
// ---------------------------------------------------------------------------
// ckeb_out
// blend stage and result register, sends zero, one or two results per pixel
// ---------------------------------------------------------------------------
module ckeb_out (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_load,
    input  ckeb_pkg::blend_t                   in_blend,
    input  ckeb_pkg::pos_t                     in_pos,
    output logic                               in_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ckeb_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_int_reg,   s1_int_next;
    logic             s1_bdr_reg,   s1_bdr_next;
    ckeb_pkg::blend_t s1_blend_reg;
    ckeb_pkg::pos_t   s1_pos_reg;

    logic                               m_valid_reg, m_valid_next;
    logic [ckeb_pkg::M_TDATA_W-1:0]     m_data_reg;
    logic                               m_last_reg;

    logic                               out_free, out_load, s1_pop;
    logic [23:0]                        int_rgb;
    logic [ckeb_pkg::M_TDATA_W-1:0]     res_data;
    logic                               res_last;

    assign out_free = !m_valid_reg || m_tready;
    assign out_load = s1_valid_reg && (s1_int_reg || s1_bdr_reg) && out_free;
    assign s1_pop   = s1_valid_reg && (!(s1_int_reg || s1_bdr_reg) ||
                      (out_free && (s1_int_reg ^ s1_bdr_reg)));
    assign in_ready = !s1_valid_reg || s1_pop;

    always_comb begin
        if (s1_blend_reg.mixed) begin
            int_rgb = {ckeb_pkg::div9(s1_blend_reg.sum_b),
                       ckeb_pkg::div9(s1_blend_reg.sum_g),
                       ckeb_pkg::div9(s1_blend_reg.sum_r)};
        end else begin
            int_rgb = s1_blend_reg.center_rgb;
        end
        // delayed interior pixel goes out before the border pixel
        if (s1_int_reg) begin
            res_data = {2'b00, int_rgb, s1_pos_reg.int_row, s1_pos_reg.int_col};
            res_last = !s1_bdr_reg;
        end else begin
            res_data = {2'b00, s1_blend_reg.cur_rgb, s1_pos_reg.bdr_row,
                        s1_pos_reg.bdr_col};
            res_last = 1'b1;
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_int_next   = s1_int_reg;
        s1_bdr_next   = s1_bdr_reg;
        if (in_load) begin
            s1_valid_next = 1'b1;
            s1_int_next   = in_pos.interior;
            s1_bdr_next   = in_pos.border;
        end else if (s1_pop) begin
            s1_valid_next = 1'b0;
        end else if (out_load) begin
            s1_int_next   = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_int_reg   <= 1'b0;
            s1_bdr_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s1_int_reg   <= s1_int_next;
            s1_bdr_reg   <= s1_bdr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            s1_blend_reg <= in_blend;
            s1_pos_reg   <= in_pos;
        end
        if (out_load) begin
            m_data_reg <= res_data;
            m_last_reg <= res_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> hdl/chroma_key_composite_edge_blend.sv
// ---------------------------------------------------------------------------
// chroma_key_composite_edge_blend
// chroma key compositor with a 3x3 blend across key edges
// ---------------------------------------------------------------------------
// Takes one raster-order pixel per beat (HSL key pixel plus foreground and
// background RGB) and accepts at most one beat per clock. Each pixel is keyed
// green or not by a small hue/saturation/lightness test and picks background
// or foreground. Two line stores (two rams of MAX_WIDTH x 25 bits, one read
// and one write per pixel) and a 3x3 window produce the interior result:
// a pixel whose window is all one kind keeps its own pick, otherwise each
// channel is the floor of the nine-sample mean. Interior results leave one
// row and one column late; border pixels leave at once with the hard pick.
// Pixels of the last column and the last row (from row and column 2 on)
// cause two result beats, the delayed interior pixel first, and the input
// waits behind them; all others cause at most one beat and the block
// sustains one pixel per clock while m_tready stays high, bound by the
// single result register. From input beat to result beat a pixel passes
// the input register, the blend register and the result register.
// Writing either size register restarts the frame at row 0, column 0;
// sizes below 3 act as 3 and sizes above the maximum as the maximum.
// ---------------------------------------------------------------------------
module chroma_key_composite_edge_blend #(
    parameter int MAX_WIDTH  = ckeb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ckeb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // configuration: 0 frame_width, 1 frame_height
    input  logic                              cfg_wr_en,
    input  logic [ckeb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ckeb_pkg::CFG_W-1:0]        cfg_wdata,

    // input pixels
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // hue, saturation, lightness, fore_red, fore_green, fore_blue,
    // back_red, back_green, back_blue, zero pad
    input  logic [ckeb_pkg::S_TDATA_W-1:0]    s_tdata,

    // result pixels
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_col, out_row, out_red, out_green, out_blue, zero pad
    output logic [ckeb_pkg::M_TDATA_W-1:0]    m_tdata,
    // last_of_item
    output logic                              m_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                          s_accept;
    logic                          s0_adv;
    logic                          s1_ready;

    // position of the pixel being accepted
    logic [CW-1:0]                 pos_col;
    ckeb_pkg::pos_t                pos_now;

    // input register, line store data arrives alongside it
    logic                          s0_valid_reg, s0_valid_next;
    ckeb_pkg::pix_t                s0_pix_reg;
    ckeb_pkg::pos_t                s0_pos_reg;
    logic [CW-1:0]                 s0_col_reg;

    logic [ckeb_pkg::WORD_W-1:0]   up_word;
    logic [ckeb_pkg::WORD_W-1:0]   mid_word;
    logic [ckeb_pkg::WORD_W-1:0]   cur_word;
    ckeb_pkg::blend_t              blend;

    assign s_tready = !s0_valid_reg || s1_ready;
    assign s_accept = s_tvalid && s_tready;
    assign s0_adv   = s0_valid_reg && s1_ready;

    ckeb_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (s_accept),
        .col       (pos_col),
        .pos       (pos_now)
    );

    always_comb begin
        if (s_accept) begin
            s0_valid_next = 1'b1;
        end else if (s0_adv) begin
            s0_valid_next = 1'b0;
        end else begin
            s0_valid_next = s0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else begin
            s0_valid_reg <= s0_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s0_pix_reg <= ckeb_pkg::pix_t'(s_tdata[ckeb_pkg::ITEM_W-1:0]);
            s0_pos_reg <= pos_now;
            s0_col_reg <= pos_col;
        end
    end

    // line stores: read at accept, rotate when the pixel moves on
    ckeb_ram #(
        .WIDTH (ckeb_pkg::WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_row (
        .aclk    (aclk),
        .wr_en   (s0_adv),
        .wr_addr (s0_col_reg),
        .wr_data (mid_word),
        .rd_en   (s_accept),
        .rd_addr (pos_col),
        .rd_data (up_word)
    );

    ckeb_ram #(
        .WIDTH (ckeb_pkg::WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_row (
        .aclk    (aclk),
        .wr_en   (s0_adv),
        .wr_addr (s0_col_reg),
        .wr_data (cur_word),
        .rd_en   (s_accept),
        .rd_addr (pos_col),
        .rd_data (mid_word)
    );

    // key test and window sums
    ckeb_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s0_adv),
        .pix      (s0_pix_reg),
        .up_word  (up_word),
        .mid_word (mid_word),
        .cur_word (cur_word),
        .blend    (blend)
    );

    // mean, selection and result beats
    ckeb_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_load  (s0_adv),
        .in_blend (blend),
        .in_pos   (s0_pos_reg),
        .in_ready (s1_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
